>>> rtl/core/assert_macros.svh
// assertion macros used by the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled in reset
`define CHK_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("slcd check failed");

// next-cycle implication, disabled in reset
`define CHK_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("slcd check failed");

`endif

>>> rtl/core/slcd_pkg.sv
// types and constants of the sensor and led command decoder
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package slcd_pkg;

    typedef struct packed {
        logic [2:0]         func;
        logic [7:0]         data;
        logic [9:0]         sample;
        logic [1:0]         channel;
        logic signed [15:0] cal_word;
    } t_in_item;

    typedef struct packed {
        logic [3:0]         action;
        logic [5:0]         index;
        logic signed [15:0] value;
        logic               nak;
    } t_out_item;

    localparam logic [2:0] FN_BYTE  = 3'd0;
    localparam logic [2:0] FN_READ  = 3'd1;
    localparam logic [2:0] FN_TICK  = 3'd2;
    localparam logic [2:0] FN_TEMP  = 3'd3;
    localparam logic [2:0] FN_LIGHT = 3'd4;
    localparam logic [2:0] FN_CAL   = 3'd5;

    localparam logic [3:0] ACT_NONE      = 4'd0;
    localparam logic [3:0] ACT_TRANSMIT  = 4'd1;
    localparam logic [3:0] ACT_EE_READ   = 4'd2;
    localparam logic [3:0] ACT_EE_WRITE  = 4'd3;
    localparam logic [3:0] ACT_LED       = 4'd4;
    localparam logic [3:0] ACT_TEMP_GO   = 4'd5;
    localparam logic [3:0] ACT_LIGHT_GO  = 4'd6;
    localparam logic [3:0] ACT_SENS      = 4'd7;
    localparam logic [3:0] ACT_SLEEP     = 4'd8;
    localparam logic [3:0] ACT_BUS_RESET = 4'd9;

    localparam logic [7:0] CMD_NONE   = 8'h00;
    localparam logic [7:0] CMD_EXT    = 8'h01;
    localparam logic [7:0] CMD_LED    = 8'h02;
    localparam logic [7:0] CMD_TCAL   = 8'h03;
    localparam logic [7:0] CMD_EEPROM = 8'h04;
    localparam logic [7:0] CMD_RSVD5  = 8'h05;
    localparam logic [7:0] CMD_TEMP   = 8'h08;
    localparam logic [7:0] CMD_LIGHT  = 8'h09;
    localparam logic [7:0] CMD_SLEEP  = 8'h0f;
    localparam logic [7:0] CMD_NOP10  = 8'h10;
    localparam logic [7:0] CMD_NOP11  = 8'h11;
    localparam logic [7:0] CMD_SENS   = 8'h19;

    localparam int unsigned       LIGHT_CHANNELS = 4;
    localparam logic [7:0]        LED_COUNT      = 8'd8;
    localparam logic [7:0]        EEPROM_SIZE    = 8'd64;
    localparam logic [7:0]        SENS_MAX       = 8'h03;
    localparam logic [5:0]        CAL_ADDR       = 6'd62;
    localparam logic signed [15:0] CAL_LIMIT     = 16'sd560;
    localparam logic [15:0]       CAL_DEFAULT    = 16'd273;
    localparam logic [7:0]        TIMEOUT_RESET  = 8'd50;

endpackage

`default_nettype wire

>>> rtl/core/slcd_core.sv
// decoder state and single-pass decode of one item into its result
// depends on slcd_pkg
`timescale 1ns / 1ps
`default_nettype none

module slcd_core import slcd_pkg::*; #(
    parameter int BUFFER_DEPTH = 4
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_fire,
    input  wire t_in_item  i_item,
    input  wire logic      i_cfg_we,
    input  wire logic [7:0] i_cfg_wdata,
    output t_out_item      o_res
);

    localparam int AW = $clog2(BUFFER_DEPTH);

    logic [7:0]    r_tlimit;
    logic [7:0]    r_cmd, n_cmd;
    logic [7:0]    r_buf [BUFFER_DEPTH];
    logic [7:0]    n_buf [BUFFER_DEPTH];
    logic [AW-1:0] r_aidx, n_aidx;
    logic [7:0]    r_idle, n_idle;
    logic [15:0]   r_toff, n_toff;
    logic [7:0]    r_trd, n_trd;
    logic [9:0]    r_traw, n_traw;
    logic [9:0]    r_light [LIGHT_CHANNELS];
    logic [9:0]    n_light [LIGHT_CHANNELS];
    logic          r_busy, n_busy;

    always_comb begin
        logic        dec;
        logic        fin;
        logic [7:0]  a0;
        logic [7:0]  a1;
        logic [7:0]  inc;
        logic [7:0]  tdiff;
        logic signed [7:0] ta;
        logic [15:0] off;

        n_cmd   = r_cmd;
        n_buf   = r_buf;
        n_aidx  = r_aidx;
        n_idle  = r_idle;
        n_toff  = r_toff;
        n_trd   = r_trd;
        n_traw  = r_traw;
        n_light = r_light;
        n_busy  = r_busy;
        o_res   = '0;
        dec     = 1'b0;
        fin     = 1'b0;
        inc     = r_idle + 8'd1;
        tdiff   = i_item.sample[7:0] - r_toff[7:0];
        ta      = signed'(tdiff);

        unique case (i_item.func)
            FN_BYTE: begin
                if (r_cmd == CMD_NONE) begin
                    n_cmd    = {4'h0, i_item.data[7:4]};
                    n_buf[0] = {4'h0, i_item.data[3:0]};
                    n_aidx   = '0;
                    n_idle   = '0;
                    dec      = i_item.data[7];
                end else begin
                    n_aidx = (r_aidx == AW'(BUFFER_DEPTH - 1)) ? '0 : r_aidx + 1'b1;
                    n_buf[n_aidx] = i_item.data;
                    dec = 1'b1;
                end
            end
            FN_READ: begin
                unique case (r_cmd)
                    CMD_EEPROM: begin
                        if (r_buf[0] < EEPROM_SIZE) begin
                            o_res.action = ACT_EE_READ;
                            o_res.index  = r_buf[0][5:0];
                        end else begin
                            o_res.action = ACT_BUS_RESET;
                        end
                        fin = 1'b1;
                    end
                    CMD_TEMP: begin
                        o_res.action = ACT_TRANSMIT;
                        o_res.value  = {8'h00, r_trd};
                        fin = 1'b1;
                    end
                    CMD_LIGHT: begin
                        o_res.action = ACT_TRANSMIT;
                        o_res.value  = {8'h00, r_light[r_buf[0][1:0]][9:2]};
                        fin = 1'b1;
                    end
                    default: o_res.action = ACT_BUS_RESET;
                endcase
            end
            FN_TICK: begin
                if (r_cmd != CMD_NONE) begin
                    n_idle = inc;
                    if (inc >= r_tlimit) begin
                        fin = 1'b1;
                        o_res.action = ACT_BUS_RESET;
                    end
                end
            end
            FN_TEMP: begin
                n_traw = i_item.sample;
                n_busy = 1'b0;
                n_trd  = 8'(ta - (ta >>> 3));
            end
            FN_LIGHT: begin
                n_light[i_item.channel] = i_item.sample;
                n_busy = 1'b0;
            end
            FN_CAL: begin
                n_toff = (i_item.cal_word > CAL_LIMIT) ? CAL_DEFAULT : i_item.cal_word;
            end
            default: ;
        endcase

        a0  = n_buf[0];
        a1  = n_buf[1];
        off = {6'h00, r_traw} - {{8{a1[7]}}, a1};

        if (dec) begin
            unique case (n_cmd)
                CMD_NONE: fin = 1'b1;
                CMD_EXT: begin
                    if (n_aidx != '0) begin
                        n_cmd  = a1;
                        n_aidx = AW'(BUFFER_DEPTH - 1);
                        n_idle = '0;
                    end
                end
                CMD_LED: begin
                    if (a0 < LED_COUNT) begin
                        o_res.action = ACT_LED;
                        o_res.index  = a0[5:0];
                        o_res.value  = {8'h00, a1};
                    end
                    fin = 1'b1;
                end
                CMD_TCAL: begin
                    if (n_aidx != '0) begin
                        if (r_traw != '0) begin
                            n_toff       = off;
                            o_res.action = ACT_EE_WRITE;
                            o_res.index  = CAL_ADDR;
                            o_res.value  = off;
                        end else begin
                            o_res.nak = 1'b1;
                        end
                        fin = 1'b1;
                    end
                end
                CMD_EEPROM: fin = (n_aidx > AW'(1));
                CMD_RSVD5:  fin = 1'b1;
                CMD_TEMP: begin
                    if (!r_busy) begin
                        n_busy       = 1'b1;
                        o_res.action = ACT_TEMP_GO;
                    end
                    n_idle = '0;
                end
                CMD_LIGHT: begin
                    if (!r_busy) begin
                        n_busy       = 1'b1;
                        o_res.action = ACT_LIGHT_GO;
                        o_res.index  = a0[5:0];
                    end
                    n_idle = '0;
                end
                CMD_SLEEP: begin
                    o_res.action = ACT_SLEEP;
                    fin = 1'b1;
                end
                CMD_NOP10, CMD_NOP11: fin = 1'b1;
                CMD_SENS: begin
                    if (n_aidx != '0) begin
                        if (a0 <= SENS_MAX && a1 != 8'h00) begin
                            o_res.action = ACT_SENS;
                            o_res.index  = a0[5:0];
                            o_res.value  = {8'h00, a1};
                        end
                        fin = 1'b1;
                    end
                end
                default: begin
                    fin       = 1'b1;
                    o_res.nak = 1'b1;
                end
            endcase
        end

        if (fin) begin
            n_cmd  = CMD_NONE;
            n_idle = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tlimit <= TIMEOUT_RESET;
            r_cmd    <= CMD_NONE;
            r_aidx   <= '0;
            r_idle   <= '0;
            r_toff   <= CAL_DEFAULT;
            r_trd    <= '0;
            r_traw   <= '0;
            r_busy   <= 1'b0;
            for (int i = 0; i < BUFFER_DEPTH; i++) begin
                r_buf[i] <= '0;
            end
            for (int i = 0; i < LIGHT_CHANNELS; i++) begin
                r_light[i] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                r_tlimit <= i_cfg_wdata;
            end
            if (i_fire) begin
                r_cmd   <= n_cmd;
                r_buf   <= n_buf;
                r_aidx  <= n_aidx;
                r_idle  <= n_idle;
                r_toff  <= n_toff;
                r_trd   <= n_trd;
                r_traw  <= n_traw;
                r_light <= n_light;
                r_busy  <= n_busy;
            end
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/sensor_led_command_decoder.sv
// an accepted item is held in the input register, decoded, and its result captured in the result register
// throughput: one item per cycle while results are taken, input and result registers around a single decode pass
// a stalled result holds the input register; input ready drops only when both are full
// reset: synchronous active low, clears decoder state, temperature offset returns to 273, timeout limit returns to 50
// top level of the sensor and led command decoder
// depends on slcd_pkg and slcd_core
`timescale 1ns / 1ps
`default_nettype none

module sensor_led_command_decoder import slcd_pkg::*; #(
    parameter int BUFFER_DEPTH = 4
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire t_in_item   i_in_item,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output t_out_item       o_out_item,
    input  wire logic       i_cfg_we,
    input  wire logic [7:0] i_cfg_wdata
);

    logic      r_in_vld;
    t_in_item  r_in;
    logic      r_out_vld;
    t_out_item r_out;
    logic      fire;
    t_out_item res;

    assign fire        = r_in_vld && (!r_out_vld || i_out_ready);
    assign o_in_ready  = !r_in_vld || fire;
    assign o_out_valid = r_out_vld;
    assign o_out_item  = r_out;

    slcd_core #(
        .BUFFER_DEPTH(BUFFER_DEPTH)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (fire),
        .i_item      (r_in),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_res       (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_vld <= i_in_valid;
            end
            if (fire) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in <= i_in_item;
        end
        if (fire) begin
            r_out <= res;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/slcd_checker.sv
// port-level checks of the decoder and their binding to the top level
// depends on slcd_pkg and assert_macros.svh
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module slcd_checker import slcd_pkg::*; (
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      o_in_ready,
    input wire logic      o_out_valid,
    input wire logic      i_out_ready,
    input wire t_out_item o_out_item
);

    logic out_stall;
    logic out_nak;
    logic out_tx;
    logic out_led;

    assign out_stall = o_out_valid && !i_out_ready;
    assign out_nak   = o_out_valid && o_out_item.nak;
    assign out_tx    = o_out_valid && o_out_item.action == ACT_TRANSMIT;
    assign out_led   = o_out_valid && o_out_item.action == ACT_LED;

    `CHK_NEXT(a_out_hold, i_clk, i_rst_n, out_stall, o_out_valid && $stable(o_out_item))
    `CHK_SAME(a_ready_low, i_clk, i_rst_n, !o_in_ready, out_stall)
    `CHK_SAME(a_nak_alone, i_clk, i_rst_n, out_nak, o_out_item.action == ACT_NONE)
    `CHK_SAME(a_tx_byte, i_clk, i_rst_n, out_tx, o_out_item.value[15:8] == 8'h00)
    `CHK_SAME(a_led_range, i_clk, i_rst_n, out_led, o_out_item.index < 6'd8)

endmodule

bind sensor_led_command_decoder slcd_checker u_slcd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_item  (o_out_item)
);

`default_nettype wire
